### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/glfe_pkg.sv
// ----------------------------------------------------------------------------
// glfe_pkg
// Shared types, constants and arithmetic helpers for the laser field evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package glfe_pkg;

  localparam int ANGLE_BITS_DEFAULT = 32;

  localparam int COS_LAT  = 7;
  localparam int ENV_LAT  = 15;
  localparam int CMB_LAT  = 2;
  localparam int PIPE_LAT = ENV_LAT + CMB_LAT;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  typedef enum logic [3:0] {
    REG_E_AMPLITUDE      = 4'd0,
    REG_B_AMPLITUDE      = 4'd1,
    REG_PHASE_OFFSET     = 4'd2,
    REG_WAVENUMBER       = 4'd3,
    REG_PULSE_CENTER_X   = 4'd4,
    REG_CENTER_Y         = 4'd5,
    REG_CENTER_Z         = 4'd6,
    REG_INV_TWO_SIGMA_SQ = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] e_amplitude;
    logic signed [31:0] b_amplitude;
    logic [31:0]        phase_offset;
    logic [31:0]        wavenumber;
    logic signed [31:0] pulse_center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [31:0]        inv_two_sigma_sq;
  } cfg_t;

  // Quarter-wave sine polynomial (Q2.30), highest order first.
  localparam logic signed [31:0] COS_C0 = 32'sd172273;
  localparam logic signed [31:0] COS_COEF [4] = '{
    -32'sd5026995, 32'sd85569306, -32'sd693598668, 32'sd1686629713
  };

  // exp(-u) polynomial (Q2.30), highest order first.
  localparam logic signed [31:0] ENV_C0 = 32'sd26631;
  localparam logic signed [31:0] ENV_COEF [8] = '{
    -32'sd213044, 32'sd1491308, -32'sd8947849, 32'sd44739243,
    -32'sd178956971, 32'sd536870912, -32'sd1073741824, 32'sd1073741824
  };

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;

  // One Horner step: coef + (acc * x) >>> 30.
  function automatic logic signed [31:0] horner_step(
    input logic signed [31:0] acc,
    input logic [30:0]        x,
    input logic signed [31:0] coef
  );
    logic signed [63:0] p;
    p = acc * $signed({1'b0, x});
    return coef + p[61:30];
  endfunction

  // Clamp a signed Q2.30 value to [0, 1.0].
  function automatic logic [30:0] clamp_q30(input logic signed [63:0] v);
    if (v < 0) return 31'd0;
    if (v > $signed({33'd0, Q30_ONE})) return Q30_ONE;
    return v[30:0];
  endfunction

endpackage

### rtl/gaussian_laser_field_evaluator.sv
// ----------------------------------------------------------------------------
// gaussian_laser_field_evaluator
// Plane-wave laser pulse with Gaussian envelope, evaluated per grid point.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out: each point yields E_y and B_z in
// Q15.16, and a new point is taken every cycle unless a result waits on the output.
// The latency is set by the envelope path: squared distance, scaling, the
// log2(e) and ln(2) products and eight Horner steps of e^-u, each behind its
// own register, followed by the cos*env and amplitude registers. The
// cosine path is shorter (seven stages) and is delayed to line up. The whole
// pipeline advances together; it holds only when the output has a result
// that is not taken. Configuration writes land immediately and must be made
// while no point is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gaussian_laser_field_evaluator #(
  parameter int ANGLE_BITS = glfe_pkg::ANGLE_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               pt_valid,
  output logic               pt_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  output logic               fld_valid,
  input  logic               fld_ready,
  output logic signed [31:0] e_field_y,
  output logic signed [31:0] b_field_z
);

  localparam int DLY = glfe_pkg::ENV_LAT - glfe_pkg::COS_LAT;

  glfe_pkg::cfg_t     cfg;
  logic               en;
  logic [glfe_pkg::PIPE_LAT:1] v;
  logic signed [31:0] cs;
  logic signed [31:0] cs_dly [0:DLY-1];
  logic [30:0]        env;

  // Advance everything unless a result is waiting on a stalled consumer.
  assign en        = fld_ready || !fld_valid;
  assign pt_ready  = en;
  assign fld_valid = v[glfe_pkg::PIPE_LAT];

  // Register file; unknown indexes drop the write.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{inv_two_sigma_sq: 32'd65536, default: '0};
    end else if (cfg_we) begin
      case (cfg_index)
        glfe_pkg::REG_E_AMPLITUDE:      cfg.e_amplitude      <= cfg_data;
        glfe_pkg::REG_B_AMPLITUDE:      cfg.b_amplitude      <= cfg_data;
        glfe_pkg::REG_PHASE_OFFSET:     cfg.phase_offset     <= cfg_data;
        glfe_pkg::REG_WAVENUMBER:       cfg.wavenumber       <= cfg_data;
        glfe_pkg::REG_PULSE_CENTER_X:   cfg.pulse_center_x   <= cfg_data;
        glfe_pkg::REG_CENTER_Y:         cfg.center_y         <= cfg_data;
        glfe_pkg::REG_CENTER_Z:         cfg.center_z         <= cfg_data;
        glfe_pkg::REG_INV_TWO_SIGMA_SQ: cfg.inv_two_sigma_sq <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits ride alongside the data stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[glfe_pkg::PIPE_LAT-1:1], pt_valid};
    end
  end

  glfe_cos #(.ANGLE_BITS(ANGLE_BITS)) u_cos (
    .clk   (clk),
    .en    (en),
    .cfg   (cfg),
    .pos_x (pos_x),
    .cs    (cs)
  );

  // Hold the cosine until the envelope catches up.
  always_ff @(posedge clk) begin
    if (en) begin
      cs_dly[0] <= cs;
      for (int j = 1; j < DLY; j++) begin
        cs_dly[j] <= cs_dly[j-1];
      end
    end
  end

  glfe_envelope u_env (
    .clk   (clk),
    .en    (en),
    .cfg   (cfg),
    .pos_x (pos_x),
    .pos_y (pos_y),
    .pos_z (pos_z),
    .env   (env)
  );

  glfe_combine u_cmb (
    .clk       (clk),
    .en        (en),
    .cfg       (cfg),
    .cs        (cs_dly[DLY-1]),
    .env       (env),
    .e_field_y (e_field_y),
    .b_field_z (b_field_z)
  );

  `ASSERT_IMPL(a_env_range, clk, rst, v[glfe_pkg::ENV_LAT], env <= glfe_pkg::Q30_ONE)
  `ASSERT_IMPL(a_cos_range, clk, rst, v[glfe_pkg::COS_LAT], (cs <= 32'sh4000_0000) && (cs >= -32'sh4000_0000))
  `ASSERT_NEXT(a_stall_hold, clk, rst, !en, $stable(v))

endmodule

### rtl/glfe_cos.sv
// ----------------------------------------------------------------------------
// glfe_cos
// Phase from wavenumber and x, then cosine by a pipelined quarter-wave sine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glfe_cos #(
  parameter int ANGLE_BITS = glfe_pkg::ANGLE_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               en,
  input  glfe_pkg::cfg_t     cfg,
  input  logic signed [31:0] pos_x,
  output logic signed [31:0] cs
);

  localparam logic [31:0] PHASE_MASK = 32'hFFFF_FFFF << (32 - ANGLE_BITS);

  logic [63:0]        kx_prod;
  logic [31:0]        phase;
  logic [30:0]        t_next;
  logic [61:0]        tt_prod;
  logic [30:0]        t_s [0:4];
  logic [30:0]        s_s [0:4];
  logic               neg_s [0:4];
  logic signed [31:0] acc_s [0:4];
  logic signed [63:0] fin_prod;
  logic [30:0]        mag;

  assign kx_prod  = {32'd0, cfg.wavenumber} * {32'd0, pos_x};
  assign t_next   = phase[30] ? {1'b0, phase[29:0]}
                              : glfe_pkg::Q30_ONE - {1'b0, phase[29:0]};
  assign tt_prod  = {31'd0, t_next} * {31'd0, t_next};
  assign fin_prod = acc_s[4] * $signed({1'b0, t_s[4]});
  assign mag      = glfe_pkg::clamp_q30(fin_prod >>> 30);

  always_ff @(posedge clk) begin
    if (en) begin
      phase    <= (cfg.phase_offset - kx_prod[31:0]) & PHASE_MASK;
      t_s[0]   <= t_next;
      s_s[0]   <= tt_prod[60:30];
      neg_s[0] <= phase[31] ^ phase[30];
      acc_s[0] <= glfe_pkg::COS_C0;
      for (int j = 1; j <= 4; j++) begin
        acc_s[j] <= glfe_pkg::horner_step(acc_s[j-1], s_s[j-1], glfe_pkg::COS_COEF[j-1]);
      end
      for (int j = 1; j <= 3; j++) begin
        s_s[j] <= s_s[j-1];
      end
      for (int j = 1; j <= 4; j++) begin
        t_s[j]   <= t_s[j-1];
        neg_s[j] <= neg_s[j-1];
      end
      cs <= neg_s[4] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule

### rtl/glfe_envelope.sv
// ----------------------------------------------------------------------------
// glfe_envelope
// Gaussian envelope: squared distance, scaling, exp by 2^-k times e^-u.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glfe_envelope (
  input  logic               clk,
  input  logic               en,
  input  glfe_pkg::cfg_t     cfg,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  output logic [30:0]        env
);

  // Exact (|a - b|)^2 >> 16 from 17-bit partial products.
  function automatic logic [48:0] sq_q16(input logic signed [31:0] a,
                                         input logic signed [31:0] b);
    logic signed [32:0] d;
    logic [32:0]        m;
    logic [49:0]        hh, hl, ll;
    d  = {a[31], a} - {b[31], b};
    m  = d[32] ? 33'(-d) : 33'(d);
    hh = m[32:16] * m[32:16];
    hl = m[32:16] * m[15:0];
    ll = m[15:0] * m[15:0];
    return 49'((hh << 16) + (hl << 1) + (ll >> 16));
  endfunction

  logic [48:0]        sqx, sqy, sqz;
  logic [50:0]        dist2;
  logic [57:0]        hi;
  logic [56:0]        lo;
  logic [41:0]        asum;
  logic [20:0]        a;
  logic               fl_a, fl_b;
  logic [51:0]        b_prod;
  logic [35:0]        b;
  logic [59:0]        u_prod;
  logic [29:0]        u_s [0:7];
  logic [5:0]         k_s [0:8];
  logic               fl_s [0:8];
  logic signed [31:0] acc_s [0:8];
  logic [30:0]        clamped;

  assign asum    = {21'd0, hi[11:0], 9'd0} + {1'b0, lo[56:16]};
  assign b_prod  = {31'd0, a} * {21'd0, glfe_pkg::LOG2E_Q30};
  assign u_prod  = {30'd0, b[29:0]} * {30'd0, glfe_pkg::LN2_Q30};
  assign clamped = glfe_pkg::clamp_q30({{32{acc_s[8][31]}}, acc_s[8]});

  always_ff @(posedge clk) begin
    if (en) begin
      sqx      <= sq_q16(pos_x, cfg.pulse_center_x);
      sqy      <= sq_q16(pos_y, cfg.center_y);
      sqz      <= sq_q16(pos_z, cfg.center_z);
      dist2    <= {2'b00, sqx} + {2'b00, sqy} + {2'b00, sqz};
      hi       <= {32'd0, dist2[50:25]} * {26'd0, cfg.inv_two_sigma_sq};
      lo       <= {32'd0, dist2[24:0]} * {25'd0, cfg.inv_two_sigma_sq};
      a        <= asum[20:0];
      fl_a     <= (|hi[57:12]) || (|asum[41:21]);
      b        <= b_prod[51:16];
      fl_b     <= fl_a;
      k_s[0]   <= b[35:30];
      fl_s[0]  <= fl_b || (b[35:30] >= 6'd31);
      u_s[0]   <= u_prod[59:30];
      acc_s[0] <= glfe_pkg::ENV_C0;
      for (int j = 1; j <= 8; j++) begin
        acc_s[j] <= glfe_pkg::horner_step(acc_s[j-1], {1'b0, u_s[j-1]},
                                          glfe_pkg::ENV_COEF[j-1]);
        k_s[j]   <= k_s[j-1];
        fl_s[j]  <= fl_s[j-1];
      end
      for (int j = 1; j <= 7; j++) begin
        u_s[j] <= u_s[j-1];
      end
      env <= fl_s[8] ? 31'd0 : clamped >> k_s[8];
    end
  end

endmodule

### rtl/glfe_combine.sv
// ----------------------------------------------------------------------------
// glfe_combine
// Cosine times envelope, then scale by each amplitude with saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glfe_combine (
  input  logic               clk,
  input  logic               en,
  input  glfe_pkg::cfg_t     cfg,
  input  logic signed [31:0] cs,
  input  logic [30:0]        env,
  output logic signed [31:0] e_field_y,
  output logic signed [31:0] b_field_z
);

  function automatic logic signed [31:0] scale_sat(input logic signed [31:0] amp,
                                                    input logic signed [31:0] c);
    logic signed [63:0] p;
    logic signed [33:0] v;
    p = amp * c;
    v = p[63:30];
    if (v > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -34'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  logic signed [63:0] ce_prod;
  logic signed [31:0] c;

  assign ce_prod = cs * $signed({1'b0, env});

  always_ff @(posedge clk) begin
    if (en) begin
      c         <= ce_prod[61:30];
      e_field_y <= scale_sat(cfg.e_amplitude, c);
      b_field_z <= scale_sat(cfg.b_amplitude, c);
    end
  end

endmodule

### bench/gaussian_laser_field_evaluator_tb.sv
// ----------------------------------------------------------------------------
// gaussian_laser_field_evaluator_tb
// Self-checking bench: streams grid points through the field evaluator under
// several register settings and compares E_y / B_z with a bit-exact predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaussian_laser_field_evaluator_tb;

  // Register indexes past the last defined one; writes there must be dropped.
  localparam logic [3:0] IDX_UNMAPPED_LO = 4'd8;
  localparam logic [3:0] IDX_UNMAPPED_HI = 4'd15;
  // Pipeline depth plus margin, waited out before config writes and at the end.
  localparam int DRAIN_CYCLES = glfe_pkg::PIPE_LAT + 8;
  localparam int RAND_PHASES = 8;
  localparam int PTS_PER_PHASE = 175;

  typedef struct {
    logic signed [31:0] e;
    logic signed [31:0] b;
  } fields_t;

  typedef struct {
    int                 seg;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    bit                 typed;
    logic signed [31:0] e;
    logic signed [31:0] b;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [3:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               pt_valid = 1'b0;
  logic               pt_ready;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic signed [31:0] pos_z = '0;
  logic               fld_valid;
  logic               fld_ready = 1'b0;
  logic signed [31:0] e_field_y;
  logic signed [31:0] b_field_z;

  glfe_pkg::cfg_t shadow_cfg;   // predictor's copy of the registers
  fields_t pending_fields[$];   // expected results, oldest first
  int      err_count = 0;
  int      points_sent = 0;
  int      fields_seen = 0;
  int      stall_mode = 0;
  int      cyc = 0;

  gaussian_laser_field_evaluator u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pt_valid  (pt_valid),
    .pt_ready  (pt_ready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .fld_valid (fld_valid),
    .fld_ready (fld_ready),
    .e_field_y (e_field_y),
    .b_field_z (b_field_z)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Field predictor
  // ---------------------------------------------------------------------------
  function automatic longint clamp_unit(longint v);
    if (v < 0) return 0;
    if (v > 64'sd1073741824) return 64'sd1073741824;
    return v;
  endfunction

  // sin of t quarter turns, t in Q1.30 within [0, 1.0]; Q2.30 out
  function automatic longint quarter_sine(longint t);
    longint s, acc;
    s = (t * t) >>> 30;
    acc = 172273;
    acc = -5026995 + ((acc * s) >>> 30);
    acc = 85569306 + ((acc * s) >>> 30);
    acc = -693598668 + ((acc * s) >>> 30);
    acc = 1686629713 + ((acc * s) >>> 30);
    return clamp_unit((acc * t) >>> 30);
  endfunction

  function automatic longint cos_turns(logic [31:0] ph);
    longint r;
    r = longint'(ph[29:0]);
    case (ph[31:30])
      2'd0:    return quarter_sine(64'sd1073741824 - r);
      2'd1:    return -quarter_sine(r);
      2'd2:    return -quarter_sine(64'sd1073741824 - r);
      default: return quarter_sine(r);
    endcase
  endfunction

  function automatic longint unsigned sq_dist(longint a, longint c);
    longint d;
    longint unsigned m;
    d = a - c;
    m = (d < 0) ? -d : d;
    return (m * m) >> 16;
  endfunction

  // exp(-dist2 * inv), Q1.30 within [0, 1.0]; flushes to zero for large arguments
  function automatic longint gauss_env(longint dist2, longint inv);
    longint hi, lo, a, bb, k, u, acc;
    hi = (dist2 >> 25) * inv;
    lo = (dist2 & 64'h1FF_FFFF) * inv;
    if (hi >= (64'sd1 << 40)) return 0;
    a = (hi << 9) + (lo >> 16);
    if (a >= (64'sd32 << 16)) return 0;
    bb = (a * 64'sd1549082005) >> 16;
    k = bb >> 30;
    if (k >= 31) return 0;
    u = ((bb & 64'h3FFF_FFFF) * 64'sd744261118) >> 30;
    acc = 26631;
    acc = -213044 + ((acc * u) >>> 30);
    acc = 1491308 + ((acc * u) >>> 30);
    acc = -8947849 + ((acc * u) >>> 30);
    acc = 44739243 + ((acc * u) >>> 30);
    acc = -178956971 + ((acc * u) >>> 30);
    acc = 536870912 + ((acc * u) >>> 30);
    acc = -1073741824 + ((acc * u) >>> 30);
    acc = 1073741824 + ((acc * u) >>> 30);
    return clamp_unit(acc) >> k;
  endfunction

  function automatic logic signed [31:0] scale_amp(logic signed [31:0] amp, longint c);
    longint v;
    v = (longint'(amp) * c) >>> 30;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic fields_t predict_fields(logic signed [31:0] x, logic signed [31:0] y,
                                             logic signed [31:0] z);
    logic [31:0] kx, ph;
    longint cs, env, c, d2;
    fields_t f;
    kx = shadow_cfg.wavenumber * x;
    ph = shadow_cfg.phase_offset - kx;
    cs = cos_turns(ph);
    d2 = sq_dist(x, shadow_cfg.pulse_center_x) + sq_dist(y, shadow_cfg.center_y) +
         sq_dist(z, shadow_cfg.center_z);
    env = gauss_env(d2, longint'(shadow_cfg.inv_two_sigma_sq));
    c = (cs * env) >>> 30;
    f.e = scale_amp(shadow_cfg.e_amplitude, c);
    f.b = scale_amp(shadow_cfg.b_amplitude, c);
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Register writes: mirror each one into the shadow copy; drop unmapped ones
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [3:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      glfe_pkg::REG_E_AMPLITUDE:      shadow_cfg.e_amplitude = val;
      glfe_pkg::REG_B_AMPLITUDE:      shadow_cfg.b_amplitude = val;
      glfe_pkg::REG_PHASE_OFFSET:     shadow_cfg.phase_offset = val;
      glfe_pkg::REG_WAVENUMBER:       shadow_cfg.wavenumber = val;
      glfe_pkg::REG_PULSE_CENTER_X:   shadow_cfg.pulse_center_x = val;
      glfe_pkg::REG_CENTER_Y:         shadow_cfg.center_y = val;
      glfe_pkg::REG_CENTER_Z:         shadow_cfg.center_z = val;
      glfe_pkg::REG_INV_TWO_SIGMA_SQ: shadow_cfg.inv_two_sigma_sq = val;
      default: ;
    endcase
  endtask

  // Hold the point stream until every result is back, then let the pipe empty.
  task automatic drain_pipe();
    pt_valid <= 1'b0;
    @(posedge clk);
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_cfg(glfe_pkg::cfg_t c);
    drain_pipe();
    write_reg(glfe_pkg::REG_E_AMPLITUDE, c.e_amplitude);
    write_reg(glfe_pkg::REG_B_AMPLITUDE, c.b_amplitude);
    write_reg(glfe_pkg::REG_PHASE_OFFSET, c.phase_offset);
    write_reg(glfe_pkg::REG_WAVENUMBER, c.wavenumber);
    write_reg(glfe_pkg::REG_PULSE_CENTER_X, c.pulse_center_x);
    write_reg(glfe_pkg::REG_CENTER_Y, c.center_y);
    write_reg(glfe_pkg::REG_CENTER_Z, c.center_z);
    write_reg(glfe_pkg::REG_INV_TWO_SIGMA_SQ, c.inv_two_sigma_sq);
    // junk to unmapped indexes must not disturb anything
    write_reg(IDX_UNMAPPED_LO + 4'($urandom_range(0, 7)), $urandom);
    // drop the write enable once the last register is in
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Point sender: raise valid with the payload, hold until the transaction
  // ---------------------------------------------------------------------------
  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, bit typed, fields_t typed_f);
    pt_valid <= 1'b1;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    do @(posedge clk); while (!pt_ready);
    pending_fields.push_back(typed ? typed_f : predict_fields(x, y, z));
    points_sent++;
  endtask

  int burst_left = 0;

  // Usually idle between bursts; bursts and gaps both of random length.
  task automatic maybe_gap();
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
    if ($urandom_range(0, 3) != 0) begin
      pt_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic glfe_pkg::cfg_t random_cfg(int ph);
    glfe_pkg::cfg_t c;
    if (ph == 0) begin
      // top of every range
      c.e_amplitude = 32'sh7FFF_FFFF;
      c.b_amplitude = 32'sh7FFF_FFFF;
      c.phase_offset = 32'hFFFF_FFFF;
      c.wavenumber = 32'hFFFF_FFFF;
      c.pulse_center_x = 32'sh7FFF_FFFF;
      c.center_y = 32'sh7FFF_FFFF;
      c.center_z = 32'sh7FFF_FFFF;
      c.inv_two_sigma_sq = 32'hFFFF_FFFF;
    end else if (ph == 1) begin
      // bottom of every range; zero inverse width makes the envelope flat
      c.e_amplitude = 32'sh8000_0000;
      c.b_amplitude = 32'sh8000_0000;
      c.phase_offset = '0;
      c.wavenumber = '0;
      c.pulse_center_x = 32'sh8000_0000;
      c.center_y = 32'sh8000_0000;
      c.center_z = 32'sh8000_0000;
      c.inv_two_sigma_sq = '0;
    end else begin
      c.e_amplitude = $urandom;
      c.b_amplitude = $urandom;
      c.phase_offset = $urandom;
      c.wavenumber = (ph % 3 == 0) ? $urandom : $urandom_range(0, 32'h4_0000);
      c.pulse_center_x = $signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
      c.center_y = $signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
      c.center_z = $signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
      c.inv_two_sigma_sq = $urandom_range(0, 32'h2_0000);
    end
    return c;
  endfunction

  // offset within +-4.0 of a centre coordinate, wrapping like the hardware
  function automatic logic signed [31:0] near(logic signed [31:0] ctr);
    return ctr + ($signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker and receiver stall pattern
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    fields_t want;
    cyc <= cyc + 1;
    if (!rst && fld_valid && fld_ready) begin
      fields_seen++;
      if (pending_fields.size() == 0) begin
        $error("unexpected result: e_field_y %0d b_field_z %0d", e_field_y, b_field_z);
        err_count++;
      end else begin
        want = pending_fields.pop_front();
        if (e_field_y !== want.e) begin
          $error("e_field_y: expected %0d, actual %0d", want.e, e_field_y);
          err_count++;
        end
        if (b_field_z !== want.b) begin
          $error("b_field_z: expected %0d, actual %0d", want.b, b_field_z);
          err_count++;
        end
      end
    end
    case (stall_mode)
      0:       fld_ready <= 1'b1;
      1:       fld_ready <= ($urandom_range(0, 9) < 6);
      2:       fld_ready <= (cyc % 13) >= 5;
      default: fld_ready <= ($urandom_range(0, 19) != 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Directed points: segment 0 runs on reset values (zero amplitude, so every
  // result is zero); segment 1 runs on a unit-envelope setting
  // ---------------------------------------------------------------------------
  localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;

  dir_row_t dir_rows[] = '{
    '{0, 32'sd0, 32'sd0, 32'sd0, 1'b1, 32'sd0, 32'sd0},
    '{0, SMAX, SMAX, SMAX, 1'b1, 32'sd0, 32'sd0},
    '{0, SMIN, SMIN, SMIN, 1'b1, 32'sd0, 32'sd0},
    '{0, SMAX, SMIN, 32'sd0, 1'b1, 32'sd0, 32'sd0},
    '{0, 32'sh0001_0000, -32'sh0001_0000, 32'sd1, 1'b1, 32'sd0, 32'sd0},
    // peak: cos = -1, env = 1, min amplitude saturates
    '{1, 32'sd0, 32'sd0, 32'sd0, 1'b0, 32'sd0, 32'sd0},
    '{1, 32'sd1, -32'sd1, 32'sd1, 1'b0, 32'sd0, 32'sd0},
    '{1, 32'sh0000_8000, 32'sd0, 32'sd0, 1'b0, 32'sd0, 32'sd0},
    '{1, 32'sh0002_0000, 32'sd0, 32'sd0, 1'b0, 32'sd0, 32'sd0},
    '{1, 32'sh0004_0000, 32'sd0, 32'sd0, 1'b0, 32'sd0, 32'sd0},
    '{1, 32'sh0004_8000, 32'sd0, 32'sd0, 1'b0, 32'sd0, 32'sd0},
    // shift count past 30 while argument still below the flush threshold
    '{1, 32'sh0005_0000, 32'sd0, 32'sd0, 1'b0, 32'sd0, 32'sd0},
    // argument of 32 or more flushes the envelope
    '{1, 32'sh0006_0000, 32'sd0, 32'sd0, 1'b1, 32'sd0, 32'sd0},
    '{1, SMAX, SMAX, SMAX, 1'b1, 32'sd0, 32'sd0},
    '{1, SMIN, SMIN, SMIN, 1'b1, 32'sd0, 32'sd0},
    '{1, 32'sd0, 32'sh0003_0000, -32'sh0002_0000, 1'b0, 32'sd0, 32'sd0},
    '{1, -32'sh0001_0000, 32'sd0, 32'sd0, 1'b0, 32'sd0, 32'sd0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    glfe_pkg::cfg_t c;
    fields_t tf;
    int seg;
    shadow_cfg = '0;
    shadow_cfg.inv_two_sigma_sq = 32'd65536;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows, full-rate receiver
    stall_mode = 0;
    seg = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].seg != seg) begin
        seg = dir_rows[i].seg;
        c = '0;
        c.e_amplitude = 32'sh0001_0000;
        c.b_amplitude = SMIN;
        c.phase_offset = 32'h8000_0000;
        c.inv_two_sigma_sq = 32'd65536;
        load_cfg(c);
      end
      tf.e = dir_rows[i].e;
      tf.b = dir_rows[i].b;
      send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].typed, tf);
    end

    // random phases: new setting each phase, mostly points near the pulse
    // centre so the envelope is live, the rest spread over the full range
    tf = '{default: '0};
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      load_cfg(random_cfg(ph));
      stall_mode = ph % 4;
      for (int n = 0; n < PTS_PER_PHASE; n++) begin
        maybe_gap();
        if ($urandom_range(0, 9) < 8)
          send_point(near(shadow_cfg.pulse_center_x), near(shadow_cfg.center_y),
                     near(shadow_cfg.center_z), 1'b0, tf);
        else
          send_point($urandom, $urandom, $urandom, 1'b0, tf);
      end
    end

    drain_pipe();
    $display("Sent %0d points over %0d register settings; checked %0d results.",
             points_sent, RAND_PHASES + 2, fields_seen);
    $display("Covered flush, saturation, extreme registers and unmapped writes.");
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
